[src/qms_pkg.sv]
// ----------------------------------------------------------------------------
// qms_pkg
// shared types, constants and helpers for the query match scorer
// ----------------------------------------------------------------------------
package qms_pkg;

  // query storage: four 64-bit words, byte i of word k is position 8*k+i
  localparam int unsigned QUERY_WORDS   = 4;
  localparam int unsigned QUERY_BYTES   = 8 * QUERY_WORDS;
  localparam int unsigned REG_W         = 64;
  localparam int unsigned ADDR_W        = 6;
  localparam int unsigned QLEN_W        = 6;
  // wide enough to compare the length register against any supported max
  localparam int unsigned LEN_CMP_W     = 7;
  localparam int unsigned SCORE_W       = 20;

  localparam int unsigned MAX_QUERY_CHARS_DEFAULT = 32;

  localparam logic [SCORE_W-1:0] SCORE_EXACT     = SCORE_W'(1000000);
  localparam logic [SCORE_W-1:0] SCORE_PREFIX    = SCORE_W'(500000);
  localparam logic [SCORE_W-1:0] SCORE_SUBSTRING = SCORE_W'(100000);

  // register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_QUERY_TEXT_0 = 3'd0,
    REG_QUERY_TEXT_1 = 3'd1,
    REG_QUERY_TEXT_2 = 3'd2,
    REG_QUERY_TEXT_3 = 3'd3,
    REG_QUERY_LEN    = 3'd4,
    REG_CMP_EXACT    = 3'd5
  } qms_reg_e;

  typedef struct packed {
    logic [QUERY_BYTES-1:0][7:0] query_bytes;
    logic [QLEN_W-1:0]           query_len;
    logic                        cmp_exact;
  } qms_cfg_t;

  // ascii A-Z to lower case unless comparing exactly
  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic exact);
    logic [7:0] r;
    r = c;
    if (!exact && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

[src/qms_cfg_regs.sv]
// ----------------------------------------------------------------------------
// qms_cfg_regs
// apb register file: query text, query length and case mode
// ----------------------------------------------------------------------------
module qms_cfg_regs
  import qms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output qms_cfg_t          cfg_o
);

  logic [QUERY_WORDS-1:0][REG_W-1:0] text_q;
  logic [QLEN_W-1:0]                 qlen_q;
  logic                              exact_q;
  logic                              wr_en;
  qms_reg_e                          reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = qms_reg_e'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q  <= '0;
      qlen_q  <= '0;
      exact_q <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_QUERY_TEXT_0: text_q[0] <= pwdata;
        REG_QUERY_TEXT_1: text_q[1] <= pwdata;
        REG_QUERY_TEXT_2: text_q[2] <= pwdata;
        REG_QUERY_TEXT_3: text_q[3] <= pwdata;
        REG_QUERY_LEN:    qlen_q    <= pwdata[QLEN_W-1:0];
        REG_CMP_EXACT:    exact_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUERY_TEXT_0: prdata = text_q[0];
      REG_QUERY_TEXT_1: prdata = text_q[1];
      REG_QUERY_TEXT_2: prdata = text_q[2];
      REG_QUERY_TEXT_3: prdata = text_q[3];
      REG_QUERY_LEN:    prdata = REG_W'(qlen_q);
      REG_CMP_EXACT:    prdata = REG_W'(exact_q);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.query_bytes = text_q;
  assign cfg_o.query_len   = qlen_q;
  assign cfg_o.cmp_exact   = exact_q;

endmodule

[src/qms_match_core.sv]
// ----------------------------------------------------------------------------
// qms_match_core
// per-position comparators, shift-and vector, prefix flag and length count
// ----------------------------------------------------------------------------
module qms_match_core
  import qms_pkg::*;
#(
  parameter int unsigned MAX_QUERY_CHARS = MAX_QUERY_CHARS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qms_cfg_t           cfg_i,
  input  logic               step_i,   // consume a nonzero byte
  input  logic               clear_i,  // end of candidate
  input  logic [7:0]         char_i,
  output logic [SCORE_W-1:0] score_o
);

  localparam int unsigned LEN_W = $clog2(MAX_QUERY_CHARS + 2);
  localparam logic [LEN_CMP_W-1:0] MAX_EXT = LEN_CMP_W'(MAX_QUERY_CHARS);
  localparam logic [LEN_W-1:0]     SAT     = LEN_W'(MAX_QUERY_CHARS + 1);

  logic [MAX_QUERY_CHARS-1:0] partial_q, partial_d;
  logic                       prefix_q, prefix_d;
  logic                       found_q, found_d;
  logic [LEN_W-1:0]           seen_q, seen_d;

  logic [LEN_CMP_W-1:0]       qlen_ext, eff_ext;
  logic [LEN_W-1:0]           len;
  logic [7:0]                 fc;
  logic [MAX_QUERY_CHARS-1:0] eq;
  logic [MAX_QUERY_CHARS-1:0] eq_shift;
  logic [MAX_QUERY_CHARS-1:0] last_mask;

  // effective length clamps at the configured maximum
  assign qlen_ext = LEN_CMP_W'(cfg_i.query_len);
  assign eff_ext  = (qlen_ext > MAX_EXT) ? MAX_EXT : qlen_ext;
  assign len      = eff_ext[LEN_W-1:0];
  assign fc       = fold_char(char_i, cfg_i.cmp_exact);

  for (genvar p = 0; p < MAX_QUERY_CHARS; p++) begin : g_cmp
    if (p < QUERY_BYTES) begin : g_byte
      assign eq[p] = (LEN_W'(p) < len) &&
                     (fold_char(cfg_i.query_bytes[p], cfg_i.cmp_exact) == fc);
    end else begin : g_zero
      // positions past the stored text hold byte zero, never matched
      assign eq[p] = (LEN_W'(p) < len) && (fc == 8'h00);
    end
  end

  assign eq_shift  = eq >> seen_q;
  assign last_mask = (len != '0) ? (MAX_QUERY_CHARS'(1) << (len - LEN_W'(1))) : '0;
  assign partial_d = ((partial_q << 1) | MAX_QUERY_CHARS'(1)) & eq;

  always_comb begin
    prefix_d = prefix_q;
    found_d  = found_q;
    seen_d   = seen_q;
    if (seen_q < len && !eq_shift[0]) begin
      prefix_d = 1'b0;
    end
    if (|(partial_d & last_mask)) begin
      found_d = 1'b1;
    end
    if (seen_q < SAT) begin
      seen_d = seen_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      prefix_q  <= 1'b1;
      found_q   <= 1'b0;
      seen_q    <= '0;
    end else if (clear_i) begin
      partial_q <= '0;
      prefix_q  <= 1'b1;
      found_q   <= 1'b0;
      seen_q    <= '0;
    end else if (step_i) begin
      partial_q <= partial_d;
      prefix_q  <= prefix_d;
      found_q   <= found_d;
      seen_q    <= seen_d;
    end
  end

  always_comb begin
    score_o = '0;
    if (len != '0) begin
      if (prefix_q && seen_q == len) begin
        score_o = SCORE_EXACT;
      end else if (prefix_q && seen_q > len) begin
        score_o = SCORE_PREFIX + SCORE_W'(len);
      end else if (found_q) begin
        score_o = SCORE_SUBSTRING + SCORE_W'(len);
      end
    end
  end

endmodule

[src/query_match_scorer.sv]
// ----------------------------------------------------------------------------
// query_match_scorer
// scores candidate strings, one byte per transaction, against a query
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------
//  in      | sink      | in_valid_i / in_stall_o   | candidate_char_i[7:0]
//  out     | source    | out_valid_o / out_stall_i | score_o[19:0], is_match_o
//  cfg     | apb slave | psel/penable/pwrite/pready| paddr[5:0], pwdata[63:0]
//
//  one byte is taken every cycle while in_stall_o is low; a zero byte's score
//  loads into the result register, raising out_valid_o, once a slot is free
//  the combinational comparator bank plus shift-and update sets the rate
//  nonzero bytes update the match state and leave the output untouched
//  a zero byte waits in the input register only while a result is stalled
//  reset clears the config registers, the match state and both valid flags
//
module query_match_scorer
  import qms_pkg::*;
#(
  parameter int unsigned MAX_QUERY_CHARS = MAX_QUERY_CHARS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [REG_W-1:0]   pwdata,
  output logic [REG_W-1:0]   prdata,
  output logic               pready,
  // candidate bytes
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         candidate_char_i,
  // scores
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SCORE_W-1:0] score_o,
  output logic               is_match_o
);

  qms_cfg_t           cfg;
  logic               s1_valid_q;
  logic [7:0]         s1_char_q;
  logic               s1_is_end;
  logic               s1_adv;
  logic               in_take;
  logic               out_free;
  logic               out_valid_q;
  logic [SCORE_W-1:0] score_q;
  logic               is_match_q;
  logic [SCORE_W-1:0] core_score;

  assign pready = 1'b1;

  qms_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // handshake: a nonzero byte always drains, an end byte needs a free result slot
  assign s1_is_end  = (s1_char_q == 8'h00);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_is_end || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  qms_match_core #(
    .MAX_QUERY_CHARS (MAX_QUERY_CHARS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (s1_adv && !s1_is_end),
    .clear_i (s1_adv && s1_is_end),
    .char_i  (s1_char_q),
    .score_o (core_score)
  );

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_char_q <= candidate_char_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_is_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload, loaded with the score of the finished candidate
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_is_end) begin
      score_q    <= core_score;
      is_match_q <= (core_score != '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign is_match_o  = is_match_q;

endmodule

[src/qms_checker.sv]
// ----------------------------------------------------------------------------
// qms_checker
// port-level checks on scores and result timing, bound to the top level
// ----------------------------------------------------------------------------
module qms_checker
  import qms_pkg::*;
#(
  parameter int unsigned MAX_QUERY_CHARS = MAX_QUERY_CHARS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [7:0]         candidate_char_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [SCORE_W-1:0] score_o,
  input  logic               is_match_o
);

  localparam logic [SCORE_W-1:0] MAX_LEN = SCORE_W'(MAX_QUERY_CHARS);

  // match flag agrees with the score
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_match_o == (score_o != '0)))
    else $error("is_match_o disagrees with score_o");

  // only the four score classes can appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (score_o == '0 || score_o == SCORE_EXACT ||
                     (score_o > SCORE_PREFIX && score_o <= SCORE_PREFIX + MAX_LEN) ||
                     (score_o > SCORE_SUBSTRING && score_o <= SCORE_SUBSTRING + MAX_LEN)))
    else $error("score_o outside the legal score classes");

  // a new result follows a zero byte that was taken and went straight on through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && candidate_char_i == 8'h00, 2))
    else $error("result without a terminating byte");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(score_o) && $stable(is_match_o)))
    else $error("stalled result changed");

endmodule

bind query_match_scorer qms_checker #(
  .MAX_QUERY_CHARS (MAX_QUERY_CHARS)
) u_qms_checker (.*);
